[design/rtbb_pkg.sv]
`default_nettype none
package rtbb_pkg;

	localparam int MAX_LEAVES_DEF = 32;
	localparam int KEY_BITS_DEF   = 64;

	localparam int IDX_BITS      = 5;
	localparam int REF_BITS      = 6;
	localparam int CNT_BITS      = 6;
	localparam int PFX_BITS      = 8;
	localparam int PRB_BITS      = 9;
	localparam int WORD_BITS     = 32;
	localparam int BOX_WORDS     = 6;
	localparam int BOX_BITS      = BOX_WORDS * WORD_BITS;
	localparam int CODE_IN_BITS  = 64;
	localparam int IN_DATA_BITS  = 288;
	localparam int OUT_DATA_BITS = 216;

	localparam logic [REF_BITS-1:0]  ROOT_REF  = 6'd63;
	localparam logic [WORD_BITS-1:0] SIGN_MASK = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] MAG_MASK  = 32'h7FFF_FFFF;

	typedef logic signed [PRB_BITS-1:0] prb_t;
	typedef logic signed [PFX_BITS-1:0] pfx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_LDI,
		ST_DP,
		ST_DN,
		ST_GROW,
		ST_SRCH,
		ST_BASE,
		ST_DNODE,
		ST_SPLIT,
		ST_NODE,
		ST_ULEAF,
		ST_ULOAD,
		ST_UCLIMB,
		ST_UMERGE,
		ST_ERD,
		ST_ELD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		state_t step;
		logic   load;
		logic   fire;
	} cmd_t;

	typedef struct packed {
		logic start_build;
		logic grow_more;
		logic srch_more;
		logic split_more;
		logic node_last;
		logic leaf_end;
		logic leaf_skip;
		logic arrived;
		logic climb_stop;
		logic rec_last;
	} stat_t;

	// ieee order on single bit patterns, signed zeros equal
	function automatic logic ieee_less(input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b);
		logic [WORD_BITS-1:0] ka;
		logic [WORD_BITS-1:0] kb;
		ka = a[WORD_BITS-1] ? ~a : (a | SIGN_MASK);
		kb = b[WORD_BITS-1] ? ~b : (b | SIGN_MASK);
		if (((a | b) & MAG_MASK) == '0) return 1'b0;
		return ka < kb;
	endfunction

endpackage
`default_nettype wire

[design/rtbb_ram.sv]
`default_nettype none
module rtbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/rtbb_ctrl.sv]
`default_nettype none
module rtbb_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire rtbb_pkg::stat_t stat,
	output rtbb_pkg::cmd_t       cmd
);
	rtbb_pkg::state_t state_q;
	rtbb_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequencing of load, build, upsweep and emit
	always_comb begin
		in_ready  = (state_q == rtbb_pkg::ST_IDLE);
		out_valid = (state_q == rtbb_pkg::ST_EOUT);
		cmd.step  = state_q;
		cmd.load  = in_valid && in_ready;
		cmd.fire  = out_valid && out_ready;
		state_nxt = state_q;
		case (state_q)
			rtbb_pkg::ST_IDLE: begin
				if (cmd.load && stat.start_build) state_nxt = rtbb_pkg::ST_INIT;
			end
			rtbb_pkg::ST_INIT:  state_nxt = rtbb_pkg::ST_LDI;
			rtbb_pkg::ST_LDI:   state_nxt = rtbb_pkg::ST_DP;
			rtbb_pkg::ST_DP:    state_nxt = rtbb_pkg::ST_DN;
			rtbb_pkg::ST_DN:    state_nxt = rtbb_pkg::ST_GROW;
			rtbb_pkg::ST_GROW: begin
				if (!stat.grow_more) state_nxt = rtbb_pkg::ST_SRCH;
			end
			rtbb_pkg::ST_SRCH: begin
				if (!stat.srch_more) state_nxt = rtbb_pkg::ST_BASE;
			end
			rtbb_pkg::ST_BASE:  state_nxt = rtbb_pkg::ST_DNODE;
			rtbb_pkg::ST_DNODE: state_nxt = rtbb_pkg::ST_SPLIT;
			rtbb_pkg::ST_SPLIT: begin
				if (!stat.split_more) state_nxt = rtbb_pkg::ST_NODE;
			end
			rtbb_pkg::ST_NODE: begin
				state_nxt = stat.node_last ? rtbb_pkg::ST_ULEAF : rtbb_pkg::ST_LDI;
			end
			rtbb_pkg::ST_ULEAF: begin
				if (stat.leaf_end) state_nxt = rtbb_pkg::ST_ERD;
				else if (!stat.leaf_skip) state_nxt = rtbb_pkg::ST_ULOAD;
			end
			rtbb_pkg::ST_ULOAD: state_nxt = rtbb_pkg::ST_UCLIMB;
			rtbb_pkg::ST_UCLIMB: begin
				state_nxt = stat.arrived ? rtbb_pkg::ST_UMERGE : rtbb_pkg::ST_ULEAF;
			end
			rtbb_pkg::ST_UMERGE: begin
				state_nxt = stat.climb_stop ? rtbb_pkg::ST_ULEAF : rtbb_pkg::ST_UCLIMB;
			end
			rtbb_pkg::ST_ERD:   state_nxt = rtbb_pkg::ST_ELD;
			rtbb_pkg::ST_ELD:   state_nxt = rtbb_pkg::ST_EOUT;
			rtbb_pkg::ST_EOUT: begin
				if (cmd.fire) state_nxt = stat.rec_last ? rtbb_pkg::ST_IDLE : rtbb_pkg::ST_ERD;
			end
			default: state_nxt = rtbb_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[design/rtbb_datapath.sv]
`default_nettype none
module rtbb_datapath #(
	parameter int MAX_LEAVES = rtbb_pkg::MAX_LEAVES_DEF,
	parameter int KEY_BITS   = rtbb_pkg::KEY_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rtbb_pkg::cmd_t                      cmd,
	output rtbb_pkg::stat_t                          stat,
	input  wire logic [rtbb_pkg::CODE_IN_BITS-1:0]   morton_code,
	input  wire logic [rtbb_pkg::BOX_BITS-1:0]       leaf_box,
	input  wire logic                                final_leaf,
	output logic [rtbb_pkg::IDX_BITS-1:0]            node_number,
	output logic                                     slot,
	output logic [rtbb_pkg::REF_BITS-1:0]            child_ref,
	output logic [rtbb_pkg::IDX_BITS-1:0]            fence,
	output logic [rtbb_pkg::REF_BITS-1:0]            parent_ref,
	output logic [rtbb_pkg::BOX_BITS-1:0]            box,
	output logic                                     final_record
);
	localparam int NODES = MAX_LEAVES - 1;
	localparam int LAW   = $clog2(MAX_LEAVES);
	localparam int NAW   = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SAW   = $clog2(2 * NODES);
	localparam int IB    = rtbb_pkg::IDX_BITS;
	localparam int CB    = rtbb_pkg::CNT_BITS;
	localparam int RB    = rtbb_pkg::REF_BITS;
	localparam int BB    = rtbb_pkg::BOX_BITS;
	localparam int WB    = rtbb_pkg::WORD_BITS;

	// common prefix length of two leaves, -1 outside the set
	function automatic rtbb_pkg::pfx_t pfx(input rtbb_pkg::prb_t ia, input rtbb_pkg::prb_t ib,
		input logic [KEY_BITS-1:0] ca, input logic [KEY_BITS-1:0] cb,
		input rtbb_pkg::prb_t nn);
		logic [KEY_BITS-1:0] x;
		logic [IB-1:0]       v;
		int                  lz;
		x  = ca ^ cb;
		v  = ia[IB-1:0] ^ ib[IB-1:0];
		lz = 0;
		if (ia < 0 || ia >= nn || ib < 0 || ib >= nn) return rtbb_pkg::pfx_t'(-1);
		if (x != '0) begin
			lz = KEY_BITS;
			for (int b = 0; b < KEY_BITS; b++) if (x[b]) lz = KEY_BITS - 1 - b;
		end else begin
			lz = IB;
			for (int b = 0; b < IB; b++) if (v[b]) lz = IB - 1 - b;
			lz = lz + KEY_BITS + WB - IB;
		end
		return rtbb_pkg::pfx_t'(lz);
	endfunction

	function automatic rtbb_pkg::prb_t mv(input rtbb_pkg::prb_t b, input rtbb_pkg::prb_t o,
		input logic pos);
		return pos ? rtbb_pkg::prb_t'(b + o) : rtbb_pkg::prb_t'(b - o);
	endfunction

	// leaf load and count
	logic [CB-1:0]       cnt_q;
	logic [CB-1:0]       n_q;
	logic                store;
	logic [CB-1:0]       n_load;
	rtbb_pkg::prb_t      nn;

	// range and split search registers
	logic [IB-1:0]       i_q;
	logic [KEY_BITS-1:0] ci_q;
	logic [KEY_BITS-1:0] base_q;
	rtbb_pkg::pfx_t      dp_q;
	rtbb_pkg::pfx_t      dmin_q;
	rtbb_pkg::pfx_t      dnode_q;
	logic                d_q;
	rtbb_pkg::prb_t      lmax_q;
	rtbb_pkg::prb_t      l_q;
	rtbb_pkg::prb_t      t_q;
	rtbb_pkg::prb_t      s_q;
	rtbb_pkg::prb_t      probe_q;
	rtbb_pkg::prb_t      first_q;
	rtbb_pkg::prb_t      last_q;

	// upsweep registers
	logic [CB-1:0]       k_q;
	logic [IB-1:0]       p_q;
	logic                side_q;
	logic [CB-1:0]       steps_q;
	logic [BB-1:0]       carry_q;
	logic                sibv_q;
	logic                sl_q;

	// node and leaf link tables
	logic [RB-1:0]       node_left_q   [NODES];
	logic [RB-1:0]       node_right_q  [NODES];
	logic [IB-1:0]       node_fence_q  [NODES];
	logic [RB-1:0]       node_parent_q [NODES];
	logic [RB-1:0]       leaf_parent_q [MAX_LEAVES];
	logic                arr_q         [NODES];
	logic                slot_v_q      [2*NODES];

	// output word registers
	logic [IB-1:0]       o_node_q;
	logic                o_sl_q;
	logic [RB-1:0]       o_child_q;
	logic [IB-1:0]       o_fence_q;
	logic [RB-1:0]       o_parent_q;
	logic [BB-1:0]       o_box_q;
	logic                o_last_q;

	// memory ports
	logic [KEY_BITS-1:0] code_rd;
	logic [BB-1:0]       box_rd;
	logic [BB-1:0]       slot_rd;
	logic                slot_we;
	logic [SAW-1:0]      slot_waddr;
	logic [SAW-1:0]      slot_raddr;
	rtbb_pkg::prb_t      probe_nxt;

	// combinational helpers
	rtbb_pkg::prb_t      ix;
	rtbb_pkg::pfx_t      pr_i;
	rtbb_pkg::pfx_t      pr_f;
	logic                dpos;
	rtbb_pkg::prb_t      l_add;
	rtbb_pkg::prb_t      t_half;
	rtbb_pkg::prb_t      s_add;
	rtbb_pkg::prb_t      t_up;
	rtbb_pkg::prb_t      tu0;
	rtbb_pkg::prb_t      j_new;
	rtbb_pkg::prb_t      first_new;
	rtbb_pkg::prb_t      last_new;
	rtbb_pkg::prb_t      sp;
	rtbb_pkg::prb_t      sp1;
	logic                lleaf;
	logic                rleaf;
	logic [RB-1:0]       up;
	logic [RB-1:0]       lref;
	logic [BB-1:0]       sib;
	logic [BB-1:0]       merged;

	rtbb_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_LEAVES)) u_code_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[LAW-1:0]),
		.wdata (morton_code[KEY_BITS-1:0]),
		.raddr (probe_nxt[LAW-1:0]),
		.rdata (code_rd)
	);

	rtbb_ram #(.WIDTH(BB), .DEPTH(MAX_LEAVES)) u_box_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[LAW-1:0]),
		.wdata (leaf_box),
		.raddr (k_q[LAW-1:0]),
		.rdata (box_rd)
	);

	rtbb_ram #(.WIDTH(BB), .DEPTH(2*NODES)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (carry_q),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	// search arithmetic
	always_comb begin
		store     = cmd.load && (cnt_q < CB'(MAX_LEAVES));
		n_load    = cnt_q + CB'(store);
		nn        = rtbb_pkg::prb_t'(n_q);
		ix        = rtbb_pkg::prb_t'(i_q);
		pr_i      = pfx(ix, probe_q, ci_q, code_rd, nn);
		pr_f      = pfx(first_q, probe_q, base_q, code_rd, nn);
		dpos      = dp_q > pr_i;
		l_add     = (pr_i > dmin_q) ? rtbb_pkg::prb_t'(l_q + t_q) : l_q;
		t_half    = t_q >>> 1;
		s_add     = (pr_f > dnode_q) ? rtbb_pkg::prb_t'(s_q + t_q) : s_q;
		t_up      = rtbb_pkg::prb_t'(t_q + rtbb_pkg::prb_t'(1)) >>> 1;
		tu0       = rtbb_pkg::prb_t'(last_q - first_q + rtbb_pkg::prb_t'(1)) >>> 1;
		j_new     = mv(ix, l_add, d_q);
		first_new = d_q ? ix : j_new;
		last_new  = d_q ? j_new : ix;
		sp        = rtbb_pkg::prb_t'(first_q + s_q);
		sp1       = rtbb_pkg::prb_t'(sp + rtbb_pkg::prb_t'(1));
		lleaf     = (s_q == '0);
		rleaf     = (sp1 == last_q);
		up        = node_parent_q[p_q[NAW-1:0]];
		lref      = leaf_parent_q[k_q[LAW-1:0]];

		// next code address
		probe_nxt = probe_q;
		case (cmd.step)
			rtbb_pkg::ST_INIT:  probe_nxt = '0;
			rtbb_pkg::ST_LDI:   probe_nxt = rtbb_pkg::prb_t'(ix + rtbb_pkg::prb_t'(1));
			rtbb_pkg::ST_NODE:  probe_nxt = rtbb_pkg::prb_t'(ix + rtbb_pkg::prb_t'(1));
			rtbb_pkg::ST_DP:    probe_nxt = rtbb_pkg::prb_t'(ix - rtbb_pkg::prb_t'(1));
			rtbb_pkg::ST_DN:    probe_nxt = mv(ix, rtbb_pkg::prb_t'(2), dpos);
			rtbb_pkg::ST_GROW: begin
				probe_nxt = (pr_i > dmin_q) ? mv(ix, lmax_q <<< 1, d_q) :
					mv(ix, lmax_q >>> 1, d_q);
			end
			rtbb_pkg::ST_SRCH: begin
				probe_nxt = (t_half != '0) ?
					mv(ix, rtbb_pkg::prb_t'(l_add + t_half), d_q) : first_new;
			end
			rtbb_pkg::ST_BASE:  probe_nxt = last_q;
			rtbb_pkg::ST_DNODE: probe_nxt = rtbb_pkg::prb_t'(first_q + tu0);
			rtbb_pkg::ST_SPLIT: probe_nxt = rtbb_pkg::prb_t'(first_q + s_add + t_up);
			default:            probe_nxt = probe_q;
		endcase

		// slot memory access
		slot_we    = (cmd.step == rtbb_pkg::ST_UCLIMB);
		slot_waddr = SAW'({p_q, side_q});
		slot_raddr = (cmd.step == rtbb_pkg::ST_UCLIMB) ? SAW'({p_q, ~side_q}) :
			SAW'({i_q, sl_q});

		// box union with the sibling slot
		sib = sibv_q ? slot_rd : '0;
		for (int c = 0; c < rtbb_pkg::BOX_WORDS; c++) begin
			if (c < 3) begin
				merged[c*WB +: WB] = rtbb_pkg::ieee_less(sib[c*WB +: WB], carry_q[c*WB +: WB]) ?
					sib[c*WB +: WB] : carry_q[c*WB +: WB];
			end else begin
				merged[c*WB +: WB] = rtbb_pkg::ieee_less(carry_q[c*WB +: WB], sib[c*WB +: WB]) ?
					sib[c*WB +: WB] : carry_q[c*WB +: WB];
			end
		end

		// status to the controller
		stat.start_build = final_leaf && (n_load >= CB'(2));
		stat.grow_more   = pr_i > dmin_q;
		stat.srch_more   = t_half != '0;
		stat.split_more  = t_q > rtbb_pkg::prb_t'(1);
		stat.node_last   = ({1'b0, i_q} + CB'(1)) == (n_q - CB'(1));
		stat.leaf_end    = k_q == n_q;
		stat.leaf_skip   = lref == rtbb_pkg::ROOT_REF;
		stat.arrived     = arr_q[p_q[NAW-1:0]];
		stat.climb_stop  = (up == rtbb_pkg::ROOT_REF) ||
			((steps_q + CB'(1)) >= (n_q - CB'(1)));
		stat.rec_last    = o_last_q;
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int e = 0; e < NODES; e++) arr_q[e] <= 1'b0;
			for (int e = 0; e < 2*NODES; e++) slot_v_q[e] <= 1'b0;
		end else begin
			if (cmd.load && final_leaf) cnt_q <= '0;
			else if (store) cnt_q <= cnt_q + CB'(1);
			if (cmd.step == rtbb_pkg::ST_INIT) begin
				for (int e = 0; e < NODES; e++) arr_q[e] <= 1'b0;
				for (int e = 0; e < 2*NODES; e++) slot_v_q[e] <= 1'b0;
			end
			if (cmd.step == rtbb_pkg::ST_UCLIMB) begin
				slot_v_q[slot_waddr] <= 1'b1;
				arr_q[p_q[NAW-1:0]]  <= 1'b1;
			end
		end
	end

	// datapath registers and link tables
	always_ff @(posedge clk) begin
		probe_q <= probe_nxt;
		case (cmd.step)
			rtbb_pkg::ST_IDLE: begin
				if (cmd.load && final_leaf) n_q <= n_load;
			end
			rtbb_pkg::ST_INIT: begin
				i_q <= '0;
				for (int e = 0; e < NODES; e++) node_parent_q[e] <= rtbb_pkg::ROOT_REF;
				for (int e = 0; e < MAX_LEAVES; e++) leaf_parent_q[e] <= rtbb_pkg::ROOT_REF;
			end
			rtbb_pkg::ST_LDI: ci_q <= code_rd;
			rtbb_pkg::ST_DP:  dp_q <= pr_i;
			rtbb_pkg::ST_DN: begin
				d_q    <= dpos;
				dmin_q <= dpos ? pr_i : dp_q;
				lmax_q <= rtbb_pkg::prb_t'(2);
			end
			rtbb_pkg::ST_GROW: begin
				if (pr_i > dmin_q) begin
					lmax_q <= lmax_q <<< 1;
				end else begin
					t_q <= lmax_q >>> 1;
					l_q <= '0;
				end
			end
			rtbb_pkg::ST_SRCH: begin
				l_q <= l_add;
				t_q <= t_half;
				if (t_half == '0) begin
					first_q <= first_new;
					last_q  <= last_new;
				end
			end
			rtbb_pkg::ST_BASE: base_q <= code_rd;
			rtbb_pkg::ST_DNODE: begin
				dnode_q <= pr_f;
				s_q     <= '0;
				t_q     <= tu0;
			end
			rtbb_pkg::ST_SPLIT: begin
				s_q <= s_add;
				t_q <= t_up;
			end
			rtbb_pkg::ST_NODE: begin
				node_left_q[i_q[NAW-1:0]]  <= {lleaf, sp[IB-1:0]};
				node_right_q[i_q[NAW-1:0]] <= {rleaf, sp1[IB-1:0]};
				node_fence_q[i_q[NAW-1:0]] <= (ix == first_q) ? last_q[IB-1:0] : first_q[IB-1:0];
				if (!lleaf && sp < rtbb_pkg::prb_t'(nn - rtbb_pkg::prb_t'(1)))
					node_parent_q[sp[NAW-1:0]] <= {1'b0, i_q};
				if (!rleaf && sp1 < rtbb_pkg::prb_t'(nn - rtbb_pkg::prb_t'(1)))
					node_parent_q[sp1[NAW-1:0]] <= {1'b1, i_q};
				if (lleaf && sp < nn) leaf_parent_q[sp[LAW-1:0]] <= {1'b0, i_q};
				if (rleaf && sp1 < nn) leaf_parent_q[sp1[LAW-1:0]] <= {1'b1, i_q};
				i_q <= i_q + IB'(1);
				if (stat.node_last) begin
					node_parent_q[0] <= rtbb_pkg::ROOT_REF;
					k_q <= '0;
				end
			end
			rtbb_pkg::ST_ULEAF: begin
				if (stat.leaf_end) begin
					i_q  <= '0;
					sl_q <= 1'b0;
				end else if (stat.leaf_skip) begin
					k_q <= k_q + CB'(1);
				end else begin
					p_q     <= lref[IB-1:0];
					side_q  <= lref[RB-1];
					steps_q <= '0;
				end
			end
			rtbb_pkg::ST_ULOAD: carry_q <= box_rd;
			rtbb_pkg::ST_UCLIMB: begin
				if (!stat.arrived) k_q <= k_q + CB'(1);
				sibv_q <= slot_v_q[slot_raddr];
			end
			rtbb_pkg::ST_UMERGE: begin
				carry_q <= merged;
				steps_q <= steps_q + CB'(1);
				if (stat.climb_stop) begin
					k_q <= k_q + CB'(1);
				end else begin
					p_q    <= up[IB-1:0];
					side_q <= up[RB-1];
				end
			end
			rtbb_pkg::ST_ERD: sibv_q <= slot_v_q[slot_raddr];
			rtbb_pkg::ST_ELD: begin
				o_node_q   <= i_q;
				o_sl_q     <= sl_q;
				o_child_q  <= sl_q ? node_right_q[i_q[NAW-1:0]] : node_left_q[i_q[NAW-1:0]];
				o_fence_q  <= node_fence_q[i_q[NAW-1:0]];
				o_parent_q <= node_parent_q[i_q[NAW-1:0]];
				o_box_q    <= sibv_q ? slot_rd : '0;
				o_last_q   <= sl_q && ({1'b0, i_q} == (n_q - CB'(2)));
			end
			rtbb_pkg::ST_EOUT: begin
				if (cmd.fire) begin
					sl_q <= ~sl_q;
					if (sl_q) i_q <= i_q + IB'(1);
				end
			end
			default: ;
		endcase
	end

	assign node_number  = o_node_q;
	assign slot         = o_sl_q;
	assign child_ref    = o_child_q;
	assign fence        = o_fence_q;
	assign parent_ref   = o_parent_q;
	assign box          = o_box_q;
	assign final_record = o_last_q;
endmodule
`default_nettype wire

[design/radix_tree_bvh_builder.sv]
// Builds a linear BVH (binary radix tree) over leaves that arrive sorted by Morton code.
// Input stream: one leaf per word, taken one per cycle while the block is idle;
// tlast marks the final leaf and starts the build. Leaves beyond MAX_LEAVES are dropped.
// Output stream: two words per internal node (left slot, then right), nodes in
// ascending order; tlast on the right slot of the last node. A set of fewer than two
// leaves produces no output and the block returns to idle at once.
// Timing: the range search per internal node is bound by the single read port of the
// key memory (one key compare per cycle); the upsweep visits each leaf (leaf check, box
// load) and then climbs one tree level at a time (climb, merge); each output word goes
// through a slot memory read, an output register load and the handshake.
// The input is not ready during a build or while words are being emitted; a stalled
// receiver simply holds the output word and the block waits.
// Reset clears the leaf count, the sequencer and the slot valid and arrival flags. Link
// tables and box memories have no reset; parent links and flags are cleared per build.
`default_nettype none
module radix_tree_bvh_builder #(
	parameter int MAX_LEAVES = rtbb_pkg::MAX_LEAVES_DEF,
	parameter int KEY_BITS   = rtbb_pkg::KEY_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// morton_code, prim_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
	input  wire logic [rtbb_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	input  wire logic                                 s_axis_tlast,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// node_number, child_ref, fence, parent_ref, box_lo_x, box_lo_y, box_lo_z,
	// box_hi_x, box_hi_y, box_hi_z, zero pad
	output logic [rtbb_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
	// slot
	output logic [0:0]                                m_axis_tuser,
	output logic                                      m_axis_tlast
);
	rtbb_pkg::cmd_t  cmd;
	rtbb_pkg::stat_t stat;

	logic [rtbb_pkg::IDX_BITS-1:0] node_number;
	logic                          slot;
	logic [rtbb_pkg::REF_BITS-1:0] child_ref;
	logic [rtbb_pkg::IDX_BITS-1:0] fence;
	logic [rtbb_pkg::REF_BITS-1:0] parent_ref;
	logic [rtbb_pkg::BOX_BITS-1:0] box;
	logic                          final_record;

	rtbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtbb_datapath #(.MAX_LEAVES(MAX_LEAVES), .KEY_BITS(KEY_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.morton_code  (s_axis_tdata[63:0]),
		.leaf_box     (s_axis_tdata[287:96]),
		.final_leaf   (s_axis_tlast),
		.node_number  (node_number),
		.slot         (slot),
		.child_ref    (child_ref),
		.fence        (fence),
		.parent_ref   (parent_ref),
		.box          (box),
		.final_record (final_record)
	);

	// output word packing
	assign m_axis_tdata = {2'b00, box, parent_ref, fence, child_ref, node_number};
	assign m_axis_tuser = slot;
	assign m_axis_tlast = final_record;

`ifndef SYNTH
	// never loading leaves while emitting
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output valid");
	// last word of a build returns the block to idle
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not idle after last word");
	// a left slot never ends the output run
	a_left_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tlast)
		else $error("left slot marked last");
`endif
endmodule
`default_nettype wire
